/* hdl/marker_xor_frame_command_link_core_macros.svh */
// Assertion macros for the marker framed command link.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MARKER_XOR_FRAME_COMMAND_LINK_CORE_MACROS_SVH
`define MARKER_XOR_FRAME_COMMAND_LINK_CORE_MACROS_SVH

// Same cycle implication, disabled while reset is asserted.
`define MXFCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next cycle implication, disabled while reset is asserted.
`define MXFCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mxfcl_pkg.sv */
// Package for the marker framed command link: codes, phases and reset values.
// No dependencies; used by marker_xor_frame_command_link_core.
package mxfcl_pkg;

	// Item modes on the input channel.
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_BYTE = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_RESP    = 2'd1;
	localparam logic [1:0] KIND_DATA    = 2'd2;
	localparam logic [1:0] KIND_PAY_ST  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIMEOUT  = 2'd1;
	localparam logic [1:0] ST_BAD_MARK = 2'd2;
	localparam logic [1:0] ST_BAD_SUM  = 2'd3;

	// Link phases.
	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_RESP_WAIT    = 3'd1;
	localparam logic [2:0] PH_RESP_COLLECT = 3'd2;
	localparam logic [2:0] PH_PAY_WAIT     = 3'd3;
	localparam logic [2:0] PH_PAY_DATA     = 3'd4;
	localparam logic [2:0] PH_PAY_XOR      = 3'd5;
	localparam logic [2:0] PH_PAY_TAIL     = 3'd6;

	// Configuration register indexes.
	localparam logic [1:0] REG_FRAME_MARKER = 2'd0;
	localparam logic [1:0] REG_CAPTURE_CMD  = 2'd1;
	localparam logic [1:0] REG_SUCCESS_ACK  = 2'd2;
	localparam logic [1:0] REG_PAY_WAIT     = 2'd3;

	// Register reset values.
	localparam logic [7:0]  RST_FRAME_MARKER = 8'd245;
	localparam logic [7:0]  RST_CAPTURE_CMD  = 8'd36;
	localparam logic [7:0]  RST_SUCCESS_ACK  = 8'd0;
	localparam logic [15:0] RST_PAY_WAIT     = 16'd3000;

	// Frame geometry: eight bytes, position of the last byte.
	localparam logic [2:0] FRAME_LAST_POS = 3'd7;

endpackage

/* hdl/marker_xor_frame_command_link_core.sv */
// Top level of the marker framed, XOR checked serial command link.
// Depends on mxfcl_pkg and marker_xor_frame_command_link_core_macros.svh.

// A command item produces an eight byte transmit frame, one byte per cycle while the
// result side keeps up, while the next item is held off at the input. Received byte
// and tick items each give at most one result. The single result register takes one
// result item per cycle when the last one has gone or is leaving; the input register
// and the result register separate the two sides, so a new item is taken while a
// finished result still waits.
module marker_xor_frame_command_link_core (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  command_code,
	input  logic [7:0]  param_one,
	input  logic [7:0]  param_two,
	input  logic [7:0]  param_three,
	input  logic [15:0] response_wait_ticks,
	input  logic [7:0]  received_byte,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic [7:0]  reply_q1,
	output logic [7:0]  reply_q2,
	output logic [7:0]  reply_q3,
	output logic [15:0] payload_length,
	output logic        last
);

`include "marker_xor_frame_command_link_core_macros.svh"

	// Configuration registers.
	logic [7:0]  frame_marker_q;
	logic [7:0]  capture_command_q;
	logic [7:0]  success_ack_q;
	logic [15:0] payload_wait_ticks_q;

	// Input register.
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [7:0]  cmd_s1;
	logic [7:0]  p1_s1;
	logic [7:0]  p2_s1;
	logic [7:0]  p3_s1;
	logic [15:0] ticks_s1;
	logic [7:0]  rx_s1;

	// Link state.
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  byte_index_q, byte_index_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  q1_q, q1_d, q2_q, q2_d, q3_q, q3_d;
	logic        head_ok_q, head_ok_d;
	logic [15:0] remaining_q, remaining_d;
	logic        capture_q, capture_d;
	logic [2:0]  tx_idx_q, tx_idx_d;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [1:0]  status_q;
	logic [7:0]  rq1_q, rq2_q, rq3_q;
	logic        last_q;

	// Result formed this cycle.
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [1:0]  res_status;
	logic        res_reply;
	logic        res_last;

	logic        out_free;
	logic        advance;
	logic        consume;
	logic [7:0]  tx_byte;
	logic [1:0]  chk_status;
	logic [15:0] remaining_dec;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || consume;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_marker_q       <= mxfcl_pkg::RST_FRAME_MARKER;
			capture_command_q    <= mxfcl_pkg::RST_CAPTURE_CMD;
			success_ack_q        <= mxfcl_pkg::RST_SUCCESS_ACK;
			payload_wait_ticks_q <= mxfcl_pkg::RST_PAY_WAIT;
		end else if (cfg_we) begin
			case (cfg_index)
				mxfcl_pkg::REG_FRAME_MARKER: frame_marker_q <= cfg_data[7:0];
				mxfcl_pkg::REG_CAPTURE_CMD:  capture_command_q <= cfg_data[7:0];
				mxfcl_pkg::REG_SUCCESS_ACK:  success_ack_q <= cfg_data[7:0];
				mxfcl_pkg::REG_PAY_WAIT:     payload_wait_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: holds the item until all of its results have been formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			cmd_s1   <= command_code;
			p1_s1    <= param_one;
			p2_s1    <= param_two;
			p3_s1    <= param_three;
			ticks_s1 <= response_wait_ticks;
			rx_s1    <= received_byte;
		end
	end

	// Byte of the transmit frame at the current position.
	always_comb begin
		case (tx_idx_q)
			3'd0:    tx_byte = frame_marker_q;
			3'd1:    tx_byte = cmd_s1;
			3'd2:    tx_byte = p1_s1;
			3'd3:    tx_byte = p2_s1;
			3'd4:    tx_byte = p3_s1;
			3'd5:    tx_byte = 8'd0;
			3'd6:    tx_byte = cmd_s1 ^ p1_s1 ^ p2_s1 ^ p3_s1;
			default: tx_byte = frame_marker_q;
		endcase
	end

	// Marker and checksum verdict shared by the response and payload ends.
	always_comb begin
		if (!head_ok_q || (rx_s1 != frame_marker_q)) begin
			chk_status = mxfcl_pkg::ST_BAD_MARK;
		end else if (xor_q != 8'd0) begin
			chk_status = mxfcl_pkg::ST_BAD_SUM;
		end else begin
			chk_status = mxfcl_pkg::ST_OK;
		end
	end

	assign remaining_dec = remaining_q - 16'd1;

	// Link control: one item step per cycle while the result register is free, a command steps once per frame byte.
	always_comb begin
		phase_d      = phase_q;
		byte_index_d = byte_index_q;
		wait_d       = wait_q;
		xor_d        = xor_q;
		q1_d         = q1_q;
		q2_d         = q2_q;
		q3_d         = q3_q;
		head_ok_d    = head_ok_q;
		remaining_d  = remaining_q;
		capture_d    = capture_q;
		tx_idx_d     = tx_idx_q;
		res_valid    = 1'b0;
		res_kind     = mxfcl_pkg::KIND_TX;
		res_byte     = 8'd0;
		res_status   = mxfcl_pkg::ST_OK;
		res_reply    = 1'b0;
		res_last     = 1'b0;
		consume      = 1'b0;
		if (advance) begin
			case (mode_s1)
				mxfcl_pkg::MODE_CMD: begin
					res_valid = 1'b1;
					res_kind  = mxfcl_pkg::KIND_TX;
					res_byte  = tx_byte;
					res_last  = (tx_idx_q == mxfcl_pkg::FRAME_LAST_POS);
					if (tx_idx_q == mxfcl_pkg::FRAME_LAST_POS) begin
						consume      = 1'b1;
						tx_idx_d     = 3'd0;
						capture_d    = (cmd_s1 == capture_command_q);
						wait_d       = ticks_s1;
						phase_d      = mxfcl_pkg::PH_RESP_WAIT;
						byte_index_d = 3'd0;
						xor_d        = 8'd0;
						head_ok_d    = 1'b0;
						remaining_d  = 16'd0;
					end else begin
						tx_idx_d = tx_idx_q + 3'd1;
					end
				end
				mxfcl_pkg::MODE_TICK: begin
					consume = 1'b1;
					if ((phase_q == mxfcl_pkg::PH_RESP_WAIT) ||
					    (phase_q == mxfcl_pkg::PH_PAY_WAIT)) begin
						if (wait_q <= 16'd1) begin
							wait_d     = 16'd0;
							res_valid  = 1'b1;
							res_status = mxfcl_pkg::ST_TIMEOUT;
							if (phase_q == mxfcl_pkg::PH_RESP_WAIT) begin
								res_kind = mxfcl_pkg::KIND_RESP;
							end else begin
								res_kind  = mxfcl_pkg::KIND_PAY_ST;
								res_reply = 1'b1;
							end
							phase_d   = mxfcl_pkg::PH_IDLE;
							capture_d = 1'b0;
						end else begin
							wait_d = wait_q - 16'd1;
						end
					end
				end
				mxfcl_pkg::MODE_BYTE: begin
					consume = 1'b1;
					case (phase_q)
						mxfcl_pkg::PH_RESP_WAIT: begin
							head_ok_d    = (rx_s1 == frame_marker_q);
							xor_d        = 8'd0;
							byte_index_d = 3'd1;
							phase_d      = mxfcl_pkg::PH_RESP_COLLECT;
						end
						mxfcl_pkg::PH_RESP_COLLECT: begin
							if (byte_index_q != mxfcl_pkg::FRAME_LAST_POS) begin
								// Positions one to six feed the checksum.
								xor_d        = xor_q ^ rx_s1;
								byte_index_d = byte_index_q + 3'd1;
								if (byte_index_q == 3'd2) q1_d = rx_s1;
								if (byte_index_q == 3'd3) q2_d = rx_s1;
								if (byte_index_q == 3'd4) q3_d = rx_s1;
							end else begin
								byte_index_d = 3'd0;
								res_valid    = 1'b1;
								res_kind     = mxfcl_pkg::KIND_RESP;
								res_status   = chk_status;
								res_reply    = 1'b1;
								if ((chk_status == mxfcl_pkg::ST_OK) && capture_q &&
								    (q3_q == success_ack_q)) begin
									phase_d = mxfcl_pkg::PH_PAY_WAIT;
									wait_d  = payload_wait_ticks_q;
								end else begin
									phase_d   = mxfcl_pkg::PH_IDLE;
									capture_d = 1'b0;
								end
							end
						end
						mxfcl_pkg::PH_PAY_WAIT: begin
							head_ok_d   = (rx_s1 == frame_marker_q);
							xor_d       = 8'd0;
							remaining_d = {q1_q, q2_q};
							if ({q1_q, q2_q} != 16'd0) begin
								phase_d = mxfcl_pkg::PH_PAY_DATA;
							end else begin
								phase_d = mxfcl_pkg::PH_PAY_XOR;
							end
						end
						mxfcl_pkg::PH_PAY_DATA: begin
							xor_d       = xor_q ^ rx_s1;
							remaining_d = remaining_dec;
							res_valid   = 1'b1;
							res_kind    = mxfcl_pkg::KIND_DATA;
							res_byte    = rx_s1;
							res_last    = (remaining_dec == 16'd0);
							if (remaining_dec == 16'd0) begin
								phase_d = mxfcl_pkg::PH_PAY_XOR;
							end
						end
						mxfcl_pkg::PH_PAY_XOR: begin
							xor_d   = xor_q ^ rx_s1;
							phase_d = mxfcl_pkg::PH_PAY_TAIL;
						end
						mxfcl_pkg::PH_PAY_TAIL: begin
							res_valid  = 1'b1;
							res_kind   = mxfcl_pkg::KIND_PAY_ST;
							res_status = chk_status;
							res_reply  = 1'b1;
							phase_d    = mxfcl_pkg::PH_IDLE;
							capture_d  = 1'b0;
						end
						default: ;
					endcase
				end
				default: begin
					consume = 1'b1;
				end
			endcase
		end
	end

	// Link state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= mxfcl_pkg::PH_IDLE;
			byte_index_q <= 3'd0;
			wait_q       <= 16'd0;
			xor_q        <= 8'd0;
			q1_q         <= 8'd0;
			q2_q         <= 8'd0;
			q3_q         <= 8'd0;
			head_ok_q    <= 1'b0;
			remaining_q  <= 16'd0;
			capture_q    <= 1'b0;
			tx_idx_q     <= 3'd0;
		end else begin
			phase_q      <= phase_d;
			byte_index_q <= byte_index_d;
			wait_q       <= wait_d;
			xor_q        <= xor_d;
			q1_q         <= q1_d;
			q2_q         <= q2_d;
			q3_q         <= q3_d;
			head_ok_q    <= head_ok_d;
			remaining_q  <= remaining_d;
			capture_q    <= capture_d;
			tx_idx_q     <= tx_idx_d;
		end
	end

	// Result register: loaded whenever the previous result has gone or is leaving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			kind_q   <= res_kind;
			byte_q   <= res_byte;
			status_q <= res_status;
			rq1_q    <= res_reply ? q1_q : 8'd0;
			rq2_q    <= res_reply ? q2_q : 8'd0;
			rq3_q    <= res_reply ? q3_q : 8'd0;
			last_q   <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign out_byte       = byte_q;
	assign status         = status_q;
	assign reply_q1       = rq1_q;
	assign reply_q2       = rq2_q;
	assign reply_q3       = rq3_q;
	assign payload_length = {rq1_q, rq2_q};
	assign last           = last_q;

	// A frame in progress always belongs to a held command item.
	`MXFCL_ASSERT_NOW(a_tx_owner, tx_idx_q != 3'd0, valid_s1 && (mode_s1 == mxfcl_pkg::MODE_CMD), "frame position without a command item")
	// While collecting a response, the start byte has always been counted.
	`MXFCL_ASSERT_NOW(a_collect_idx, phase_q == mxfcl_pkg::PH_RESP_COLLECT, byte_index_q != 3'd0, "response collection at position zero")
	// The last flag is only carried by transmit and payload data results.
	`MXFCL_ASSERT_NOW(a_last_kind, out_valid_q && last_q, (kind_q == mxfcl_pkg::KIND_TX) || (kind_q == mxfcl_pkg::KIND_DATA), "last flag on a status item")
	// Emitting the final frame byte leaves the link waiting for a response.
	`MXFCL_ASSERT_NEXT(a_frame_end, advance && (mode_s1 == mxfcl_pkg::MODE_CMD) && (tx_idx_q == mxfcl_pkg::FRAME_LAST_POS), (phase_q == mxfcl_pkg::PH_RESP_WAIT) && (tx_idx_q == 3'd0), "frame end did not start the response wait")

endmodule
